[src/tts_pkg.sv]
// ============================================================================
// tts_pkg
// Shared types and constants of the tick task scheduler.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    localparam int SLICE_W     = 16;
    localparam int TIME_W      = 48;
    localparam int TASK_ID_W   = 6;
    localparam int CPU_ID_W    = 2;
    localparam int HOME_W      = 3;
    localparam int STATE_W     = 2;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_TICK = 1'b1
    } cmd_code_t;

    typedef enum logic [STATE_W-1:0] {
        ST_READY  = 2'd0,
        ST_SLEEP  = 2'd1,
        ST_DELETE = 2'd2,
        ST_RSVD   = 2'd3
    } task_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_ADD,
        OP_PUSH,
        OP_SCAN,
        OP_RL,
        OP_RG,
        OP_DECIDE,
        OP_HOME,
        OP_SLEEP,
        OP_PICK,
        OP_COMMIT,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_SLP_L,
        SRC_SLP_G,
        SRC_FIFO_L,
        SRC_FIFO_G
    } src_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic        is_tick;
        logic        cpu_ok;
        logic        task_ok;
        logic        work_done;
        logic        sw;
        logic        idle;
        task_state_t st;
        logic        out_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

[src/tts_ctrl.sv]
// ============================================================================
// tts_ctrl
// Sequencer of the tick task scheduler: steps the datapath through one item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tts_ctrl
    import tts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_axis_tvalid,
    output logic         s_axis_tready,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ADD,
        S_PUSH,
        S_SCAN,
        S_RL,
        S_RG,
        S_DECIDE,
        S_BRANCH,
        S_HOME,
        S_SLEEP,
        S_RESCAN,
        S_PICK,
        S_COMMIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.op     = OP_START;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.is_tick)
                    state_next = sts.cpu_ok ? S_SCAN : S_FINISH;
                else
                    state_next = sts.task_ok ? S_ADD : S_FINISH;
            end
            S_ADD:
            begin
                cmd.op     = OP_ADD;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op     = OP_PUSH;
                state_next = sts.is_tick ? S_PICK : S_FINISH;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (sts.work_done)
                    state_next = S_RL;
            end
            S_RL:
            begin
                cmd.op     = OP_RL;
                state_next = S_RG;
            end
            S_RG:
            begin
                cmd.op     = OP_RG;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (!sts.sw)
                    state_next = S_FINISH;
                else if (sts.idle)
                    state_next = S_PICK;
                else if (sts.st == ST_READY)
                    state_next = S_HOME;
                else if (sts.st == ST_SLEEP)
                    state_next = S_SLEEP;
                else
                    state_next = S_PICK;
            end
            S_HOME:
            begin
                cmd.op     = OP_HOME;
                state_next = S_PUSH;
            end
            S_SLEEP:
            begin
                cmd.op     = OP_SLEEP;
                state_next = S_RESCAN;
            end
            S_RESCAN:
            begin
                cmd.op = OP_SCAN;
                if (sts.work_done)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.op     = OP_PICK;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[src/tts_dp.sv]
// ============================================================================
// tts_dp
// Datapath: ready FIFOs, sleeper table, per-CPU state, slot divider, result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tts_dp
    import tts_pkg::*;
#(
    parameter int NUM_CPUS   = 4,
    parameter int MAX_TASKS  = 64,
    parameter int FIFO_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [SLICE_W-1:0]     cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire dp_cmd_t                cmd,
    output dp_sts_t                     sts
);

    localparam int NQ    = NUM_CPUS + 1;
    localparam int QW    = $clog2(NQ);
    localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int TW    = $clog2(MAX_TASKS);
    localparam int SW    = TW + 1;
    localparam int FW    = $clog2(FIFO_DEPTH);
    localparam int CNW   = $clog2(FIFO_DEPTH + 1);
    localparam int PW    = FW + 2;
    localparam int SLOTS = NQ * FIFO_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int XW    = TIME_W + 1;
    localparam int DW    = SLICE_W + CW + 1;
    localparam int DCW   = $clog2(XW + 1);
    localparam int MW    = CPU_ID_W + SLICE_W;

    localparam logic [QW-1:0] GEN_Q = QW'(NUM_CPUS);

    // input fields
    logic [CPU_ID_W-1:0]  in_cpu;
    logic [TASK_ID_W-1:0] in_task;
    logic [HOME_W-1:0]    in_home;
    logic [TIME_W-1:0]    in_now;
    logic [STATE_W-1:0]   in_st;
    logic [TIME_W-1:0]    in_wake;

    assign in_cpu  = s_axis_tdata[1:0];
    assign in_task = s_axis_tdata[7:2];
    assign in_home = s_axis_tdata[10:8];
    assign in_now  = s_axis_tdata[58:11];
    assign in_st   = s_axis_tdata[60:59];
    assign in_wake = s_axis_tdata[108:61];

    // control state
    logic [SLICE_W-1:0]  slice_reg;
    logic                is_tick_reg;
    logic                cpu_ok_reg;
    logic                task_ok_reg;
    logic [SW-1:0]       scan_idx_reg;
    logic                pipe_v_reg;
    logic [DCW-1:0]      div_cnt_reg;
    logic                bl_v_reg;
    logic                bg_v_reg;
    logic                rl_reg;
    logic                rg_reg;
    logic                wl_reg;
    logic                wg_reg;
    logic                sw_reg;
    logic                drop_reg;
    logic                pick_v_reg;
    logic                pick_mem_reg;
    logic                out_valid_reg;
    logic                sleeper_valid_reg [MAX_TASKS];
    logic [CNW-1:0]      count_reg [NQ];
    logic [FW-1:0]       head_reg [NQ];
    logic [TW-1:0]       run_task_reg [NUM_CPUS];
    logic                run_idle_reg [NUM_CPUS];
    logic                prefer_reg [NUM_CPUS];

    // payload
    logic [CW-1:0]       cpu_reg;
    logic [TW-1:0]       task_reg;
    logic [QW-1:0]       home_q_reg;
    logic [TIME_W-1:0]   now_reg;
    task_state_t         st_reg;
    logic [TIME_W-1:0]   wake_reg;
    logic [XW-1:0]       x_reg;
    logic [DW-1:0]       d_reg;
    logic [DW-1:0]       rem_reg;
    logic                rd_vld_reg;
    logic [TW-1:0]       rd_idx_reg;
    logic [TIME_W-1:0]   wake_rd_reg;
    logic [QW-1:0]       home_rd_reg;
    logic [TIME_W-1:0]   bl_wake_reg;
    logic [TW-1:0]       bl_idx_reg;
    logic [TIME_W-1:0]   bg_wake_reg;
    logic [TW-1:0]       bg_idx_reg;
    logic [QW-1:0]       push_q_reg;
    logic [TW-1:0]       push_task_reg;
    logic [TW-1:0]       pick_task_reg;
    logic [TW-1:0]       slot_rd_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [TIME_W-1:0]   wake_mem [MAX_TASKS];
    logic [QW-1:0]       home_mem [MAX_TASKS];
    logic [TW-1:0]       slot_mem [SLOTS];

    // combinational
    logic [CW-1:0]       cpu_q;
    logic [QW-1:0]       cpu_qq;
    logic [SLICE_W-1:0]  sl_eff;
    logic [MW-1:0]       cpu_off;
    logic [QW-1:0]       add_q;
    logic [DW:0]         rem_sh;
    logic                scan_end;
    logic                div_end;
    logic [TW-1:0]       old_idx;
    logic [TW-1:0]       rd_addr;
    logic                wl;
    logic                wg;
    logic                avail;
    logic                cur_idle;
    logic                sw;
    src_t                src;
    logic [QW-1:0]       q_idx;
    logic [CNW-1:0]      cnt_sel;
    logic [FW-1:0]       head_sel;
    logic [PW-1:0]       pos_sum;
    logic [PW-1:0]       pos;
    logic [AW-1:0]       q_base;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_slot_addr;
    logic                fifo_full;
    logic [FW-1:0]       head_inc;
    logic [TW-1:0]       new_task;
    logic [TASK_ID_W-1:0] res_task;
    logic                res_idle;
    logic                res_live;

    assign cpu_q    = cpu_reg;
    assign cpu_qq   = QW'(cpu_reg);
    assign sl_eff   = (slice_reg == '0) ? SLICE_W'(1) : slice_reg;
    assign cpu_off  = MW'(in_cpu) * MW'(sl_eff);
    assign add_q    = (in_home[HOME_W-1] == 1'b0 && int'(in_home) < NUM_CPUS)
                      ? QW'(in_home) : GEN_Q;
    assign rem_sh   = {rem_reg, x_reg[XW-1]};
    assign scan_end = (scan_idx_reg == SW'(MAX_TASKS));
    assign div_end  = (div_cnt_reg == DCW'(XW));
    assign old_idx  = run_task_reg[cpu_q];
    assign rd_addr  = (cmd.op == OP_SCAN) ? scan_idx_reg[TW-1:0] : old_idx;
    assign cur_idle = run_idle_reg[cpu_q];

    assign wl    = bl_v_reg && (now_reg >= bl_wake_reg);
    assign wg    = bg_v_reg && (now_reg >= bg_wake_reg);
    assign avail = wl || wg || rl_reg || rg_reg;
    assign sw    = (!cur_idle && (st_reg == ST_SLEEP || st_reg == ST_DELETE))
                   || (cur_idle && avail) || ((rem_reg == '0) && avail);

    always_comb
    begin
        if (prefer_reg[cpu_q])
        begin
            if (wl_reg)      src = SRC_SLP_L;
            else if (wg_reg) src = SRC_SLP_G;
            else if (rl_reg) src = SRC_FIFO_L;
            else if (rg_reg) src = SRC_FIFO_G;
            else             src = SRC_NONE;
        end
        else
        begin
            if (wg_reg)      src = SRC_SLP_G;
            else if (wl_reg) src = SRC_SLP_L;
            else if (rg_reg) src = SRC_FIFO_G;
            else if (rl_reg) src = SRC_FIFO_L;
            else             src = SRC_NONE;
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_RG:   q_idx = GEN_Q;
            OP_PUSH: q_idx = push_q_reg;
            OP_PICK: q_idx = (src == SRC_FIFO_L) ? cpu_qq : GEN_Q;
            default: q_idx = cpu_qq;
        endcase
    end

    assign cnt_sel      = count_reg[q_idx];
    assign head_sel     = head_reg[q_idx];
    assign fifo_full    = (cnt_sel == CNW'(FIFO_DEPTH));
    assign pos_sum      = PW'(head_sel) + PW'(cnt_sel);
    assign pos          = (pos_sum >= PW'(FIFO_DEPTH)) ? pos_sum - PW'(FIFO_DEPTH) : pos_sum;
    assign q_base       = AW'(q_idx) * AW'(FIFO_DEPTH);
    assign wr_addr      = q_base + AW'(pos);
    assign rd_slot_addr = q_base + AW'(head_sel);
    assign head_inc     = (head_sel == FW'(FIFO_DEPTH - 1)) ? '0 : head_sel + FW'(1);
    assign new_task     = pick_mem_reg ? slot_rd_reg : pick_task_reg;

    assign res_live = is_tick_reg && cpu_ok_reg;
    assign res_idle = res_live && run_idle_reg[cpu_q];
    assign res_task = (res_live && !run_idle_reg[cpu_q])
                      ? TASK_ID_W'(run_task_reg[cpu_q]) : '0;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg     <= SLICE_RESET;
            is_tick_reg   <= 1'b0;
            cpu_ok_reg    <= 1'b0;
            task_ok_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            pipe_v_reg    <= 1'b0;
            div_cnt_reg   <= '0;
            bl_v_reg      <= 1'b0;
            bg_v_reg      <= 1'b0;
            rl_reg        <= 1'b0;
            rg_reg        <= 1'b0;
            wl_reg        <= 1'b0;
            wg_reg        <= 1'b0;
            sw_reg        <= 1'b0;
            drop_reg      <= 1'b0;
            pick_v_reg    <= 1'b0;
            pick_mem_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
                sleeper_valid_reg[i] <= 1'b0;
            for (int i = 0; i < NQ; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                run_task_reg[i] <= '0;
                run_idle_reg[i] <= 1'b1;
                prefer_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
                slice_reg <= cfg_wdata;
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                OP_START:
                begin
                    is_tick_reg  <= (cmd_code_t'(s_axis_tuser) == CMD_TICK);
                    cpu_ok_reg   <= (int'(in_cpu) < NUM_CPUS);
                    task_ok_reg  <= (int'(in_task) < MAX_TASKS);
                    scan_idx_reg <= '0;
                    pipe_v_reg   <= 1'b0;
                    div_cnt_reg  <= '0;
                    bl_v_reg     <= 1'b0;
                    bg_v_reg     <= 1'b0;
                    rl_reg       <= 1'b0;
                    rg_reg       <= 1'b0;
                    sw_reg       <= 1'b0;
                    drop_reg     <= 1'b0;
                end
                OP_PUSH:
                begin
                    if (fifo_full)
                        drop_reg <= 1'b1;
                    else
                        count_reg[q_idx] <= cnt_sel + CNW'(1);
                end
                OP_SCAN:
                begin
                    if (!div_end)
                        div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (!scan_end)
                    begin
                        scan_idx_reg <= scan_idx_reg + SW'(1);
                        pipe_v_reg   <= 1'b1;
                    end
                    else
                    begin
                        pipe_v_reg <= 1'b0;
                    end
                    if (pipe_v_reg && rd_vld_reg)
                    begin
                        if (home_rd_reg == cpu_qq && (!bl_v_reg || wake_rd_reg < bl_wake_reg))
                            bl_v_reg <= 1'b1;
                        if (home_rd_reg == GEN_Q && (!bg_v_reg || wake_rd_reg < bg_wake_reg))
                            bg_v_reg <= 1'b1;
                    end
                end
                OP_RL:
                begin
                    rl_reg <= (cnt_sel != '0);
                end
                OP_RG:
                begin
                    rg_reg <= (cnt_sel != '0);
                end
                OP_DECIDE:
                begin
                    wl_reg <= wl;
                    wg_reg <= wg;
                    sw_reg <= sw;
                end
                OP_SLEEP:
                begin
                    sleeper_valid_reg[old_idx] <= 1'b1;
                    scan_idx_reg <= '0;
                    pipe_v_reg   <= 1'b0;
                    bl_v_reg     <= 1'b0;
                    bg_v_reg     <= 1'b0;
                end
                OP_PICK:
                begin
                    pick_v_reg   <= (src != SRC_NONE);
                    pick_mem_reg <= (src == SRC_FIFO_L || src == SRC_FIFO_G);
                    if (src == SRC_SLP_L)
                        sleeper_valid_reg[bl_idx_reg] <= 1'b0;
                    if (src == SRC_SLP_G)
                        sleeper_valid_reg[bg_idx_reg] <= 1'b0;
                    if (src == SRC_FIFO_L || src == SRC_FIFO_G)
                    begin
                        head_reg[q_idx]  <= head_inc;
                        count_reg[q_idx] <= cnt_sel - CNW'(1);
                    end
                end
                OP_COMMIT:
                begin
                    run_idle_reg[cpu_q] <= !pick_v_reg;
                    run_task_reg[cpu_q] <= pick_v_reg ? new_task : '0;
                    prefer_reg[cpu_q]   <= !prefer_reg[cpu_q];
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and storage
    always_ff @(posedge clk)
    begin
        wake_rd_reg <= wake_mem[rd_addr];
        home_rd_reg <= home_mem[rd_addr];
        slot_rd_reg <= slot_mem[rd_slot_addr];
        unique case (cmd.op)
            OP_START:
            begin
                cpu_reg    <= CW'(in_cpu);
                task_reg   <= TW'(in_task);
                home_q_reg <= add_q;
                now_reg    <= in_now;
                st_reg     <= task_state_t'(in_st);
                wake_reg   <= in_wake;
                x_reg      <= XW'(in_now) + XW'(cpu_off);
                d_reg      <= DW'(NUM_CPUS) * DW'(sl_eff);
                rem_reg    <= '0;
            end
            OP_ADD:
            begin
                home_mem[task_reg] <= home_q_reg;
                push_q_reg         <= home_q_reg;
                push_task_reg      <= task_reg;
            end
            OP_PUSH:
            begin
                if (!fifo_full)
                    slot_mem[wr_addr] <= push_task_reg;
            end
            OP_SCAN:
            begin
                if (!div_end)
                begin
                    rem_reg <= (rem_sh >= {1'b0, d_reg}) ? DW'(rem_sh - {1'b0, d_reg})
                                                         : DW'(rem_sh);
                    x_reg   <= x_reg << 1;
                end
                rd_vld_reg <= sleeper_valid_reg[scan_idx_reg[TW-1:0]];
                rd_idx_reg <= scan_idx_reg[TW-1:0];
                if (pipe_v_reg && rd_vld_reg)
                begin
                    if (home_rd_reg == cpu_qq && (!bl_v_reg || wake_rd_reg < bl_wake_reg))
                    begin
                        bl_wake_reg <= wake_rd_reg;
                        bl_idx_reg  <= rd_idx_reg;
                    end
                    if (home_rd_reg == GEN_Q && (!bg_v_reg || wake_rd_reg < bg_wake_reg))
                    begin
                        bg_wake_reg <= wake_rd_reg;
                        bg_idx_reg  <= rd_idx_reg;
                    end
                end
            end
            OP_HOME:
            begin
                push_q_reg    <= home_rd_reg;
                push_task_reg <= old_idx;
            end
            OP_SLEEP:
            begin
                wake_mem[old_idx] <= wake_reg;
            end
            OP_PICK:
            begin
                pick_task_reg <= (src == SRC_SLP_G) ? bg_idx_reg : bl_idx_reg;
            end
            OP_EMIT:
            begin
                out_data_reg <= OUT_TDATA_W'({drop_reg, res_idle, res_task, sw_reg});
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign sts.is_tick   = is_tick_reg;
    assign sts.cpu_ok    = cpu_ok_reg;
    assign sts.task_ok   = task_ok_reg;
    assign sts.work_done = scan_end && !pipe_v_reg && div_end;
    assign sts.sw        = sw_reg;
    assign sts.idle      = cur_idle;
    assign sts.st        = st_reg;
    assign sts.out_busy  = out_valid_reg && !m_axis_tready;

endmodule

`default_nettype wire

[src/tick_task_scheduler.sv]
// ============================================================================
// tick_task_scheduler
// Tick-driven task scheduler with per-CPU and generic ready FIFOs and sleepers.
// ============================================================================
//  channel   dir  signals                         payload
//  s_axis    in   tvalid tready tdata[111:0] tuser  add or tick command
//  m_axis    out  tvalid tready tdata[15:0]         one result per command
//  cfg       in   cfg_we cfg_wdata[15:0]            slice_ticks
//
//  Add: check, add and push, then the result. Tick: a sleeper scan of all MAX_TASKS
//  entries, one entry a cycle, with the 49-step slot remainder alongside; without a
//  switch the result follows; with one a task is picked and committed, after the old
//  task is requeued if it is ready; putting it to sleep rescans before the pick.
//  One item at a time; a new item is taken while the last result still waits,
//  and a stalled result holds the next one back in S_FINISH until it is taken.
//  Reset empties all FIFOs and sleepers and idles every CPU; no clearing pass.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tick_task_scheduler
    import tts_pkg::*;
#(
    parameter int NUM_CPUS   = 4,
    parameter int MAX_TASKS  = 64,
    parameter int FIFO_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [SLICE_W-1:0]     cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cpu_id[1:0] task_id[7:2] task_home[10:8] now[58:11] cur_state[60:59]
    // wake_time[108:61]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // switched[0] next_task[6:1] next_idle[7] dropped[8]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    tts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    tts_dp #(
        .NUM_CPUS   (NUM_CPUS),
        .MAX_TASKS  (MAX_TASKS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

[src/tts_checker.sv]
// ============================================================================
// tts_checker
// Port-level checks of the tick task scheduler.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tts_checker
    import tts_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer taken while busy");

    a_idle_no_task: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6:1] == '0)
        else $error("idle CPU reports a task");

    a_drop_add: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] && !m_axis_tdata[0]
            |-> m_axis_tdata[7:1] == '0)
        else $error("add result carries CPU state");

endmodule

bind tick_task_scheduler tts_checker u_chk (.*);

`default_nettype wire
